FILE: design/sd_spi_host_sequencer_unit_macros.svh
// assertion macros shared by the checker
`ifndef SD_SPI_HOST_SEQUENCER_UNIT_MACROS_SVH
`define SD_SPI_HOST_SEQUENCER_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SDH_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sdh check failed");

// next-cycle implication, disabled during reset
`define SDH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdh check failed");

`endif

FILE: design/sdh_pkg.sv
package sdh_pkg;

    localparam int SECTOR_BYTES    = 512;
    localparam int INIT_FILL_BYTES = 12;
    localparam int CNT_MAX = (SECTOR_BYTES > INIT_FILL_BYTES) ? SECTOR_BYTES : INIT_FILL_BYTES;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);

    localparam int IN_DATA_W  = 40;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 24;

    // output tdata bit positions
    localparam int OUT_CSN_BIT  = 8;
    localparam int OUT_WANT_BIT = 18;
    localparam int OUT_BUSY_BIT = 19;
    localparam int OUT_DONE_BIT = 20;

    typedef enum logic [1:0] {
        ACT_XFER  = 2'd0,
        ACT_INIT  = 2'd1,
        ACT_READ  = 2'd2,
        ACT_WRITE = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_CMD_REJ  = 3'd1,
        ST_CRC_ERR  = 3'd2,
        ST_WR_ERR   = 3'd3,
        ST_RESP_ERR = 3'd4
    } status_t;

    typedef enum logic [4:0] {
        PH_IDLE, PH_FILL, PH_CMD0, PH_R1_0, PH_CMD1, PH_R1_1, PH_INIT_TAIL,
        PH_RD_CMD, PH_RD_R1, PH_RD_TOKEN, PH_RD_DATA, PH_RD_CRC,
        PH_WR_CMD, PH_WR_R1, PH_WR_PRE, PH_WR_DATA, PH_WR_TAIL, PH_WR_RESP,
        PH_WR_BUSY
    } phase_t;

    localparam logic [7:0] CMD0_CODE   = 8'h40;
    localparam logic [7:0] CMD0_CRC    = 8'h95;
    localparam logic [7:0] CMD1_CODE   = 8'h41;
    localparam logic [7:0] CMD17_CODE  = 8'h51;
    localparam logic [7:0] CMD24_CODE  = 8'h58;
    localparam logic [7:0] BLOCK_TOKEN = 8'hFE;
    localparam logic [7:0] FILLER      = 8'h55;
    localparam logic [7:0] IDLE_BYTE   = 8'hFF;
    localparam logic [4:0] RESP_OK     = 5'h05;
    localparam logic [4:0] RESP_CRC    = 5'h0B;
    localparam logic [4:0] RESP_WRERR  = 5'h0D;

    // byte idx of the six-byte command frame for the command of a phase
    function automatic logic [7:0] frame_byte(phase_t ph, logic [2:0] idx, logic [23:0] arg_in);
        logic [7:0]  code;
        logic [7:0]  crc;
        logic [23:0] arg;
        logic [7:0]  res;
        code = CMD24_CODE;
        crc  = IDLE_BYTE;
        arg  = arg_in;
        if (ph == PH_CMD0)
        begin
            code = CMD0_CODE;
            crc  = CMD0_CRC;
            arg  = '0;
        end
        else if (ph == PH_CMD1)
        begin
            code = CMD1_CODE;
            arg  = '0;
        end
        else if (ph == PH_RD_CMD)
        begin
            code = CMD17_CODE;
        end
        case (idx)
            3'd0:    res = code;
            3'd1:    res = arg[23:16];
            3'd2:    res = arg[15:8];
            3'd3:    res = arg[7:0];
            3'd4:    res = 8'h00;
            default: res = crc;
        endcase
        return res;
    endfunction

endpackage

FILE: design/sd_spi_host_sequencer_unit.sv
// SD card host sequencer for SPI mode, one byte slot per transfer.
// Input stream: s_axis_tuser carries the action (0 byte exchanged, 1 init,
// 2 sector read, 3 sector write), s_axis_tdata carries the sector address,
// the byte received for the previously sent byte and the next write byte.
// Output stream: one result per input transfer, giving the next byte to
// shift out, chip select, clock select, operation flags and status;
// m_axis_tuser marks a result whose read_byte holds sector data.
// The result of a transfer accepted at an edge is registered and valid
// after that edge. Throughput is one transfer per cycle while the
// receiver does not stall; the next byte is picked by one level of phase
// decode between the sequencer state registers and the output register.
// Reset puts the sequencer idle with the card deselected, slow clock and
// status ok. When the receiver stalls, the output register holds its
// result and s_axis_tready drops, so no transfer is taken until the held
// result is taken; in the cycle it is taken a new transfer may enter.
module sd_spi_host_sequencer_unit
    import sdh_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // sector_addr[23:0], miso_byte[31:24], write_byte[39:32]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // action[1:0]
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // mosi_byte[7:0], cs_n[8], fast_clock[9], read_byte[17:10],
    // want_write_byte[18], busy_res[19], done_res[20], status[23:21]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // read_valid[0]
    output logic                  m_axis_tuser
);

    phase_t                phase_reg, phase_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [23:0]           addr_reg, addr_next;
    logic                  fast_reg, fast_next;
    logic                  sel_reg, sel_next;
    status_t               status_reg, status_next;

    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  out_user_reg;

    logic                  accept;
    action_t               action;
    logic [7:0]            miso;
    logic [7:0]            wbyte;
    logic [4:0]            resp;

    logic [7:0]            mosi;
    logic                  rvalid;
    logic [7:0]            rbyte;
    logic                  want;
    logic                  done;
    logic                  busy;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign action        = action_t'(s_axis_tuser);
    assign miso          = s_axis_tdata[31:24];
    assign wbyte         = s_axis_tdata[39:32];
    assign resp          = miso[4:0];

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        addr_next   = addr_reg;
        fast_next   = fast_reg;
        sel_next    = sel_reg;
        status_next = status_reg;
        mosi        = IDLE_BYTE;
        rvalid      = 1'b0;
        rbyte       = 8'h00;
        want        = 1'b0;
        done        = 1'b0;

        if (phase_reg == PH_IDLE && action != ACT_XFER)
        begin
            status_next = ST_OK;
            count_next  = '0;
            if (action == ACT_INIT)
            begin
                fast_next  = 1'b0;
                sel_next   = 1'b1;
                phase_next = PH_FILL;
                count_next = CNT_W'(1);
            end
            else
            begin
                addr_next  = s_axis_tdata[23:0];
                sel_next   = 1'b0;
                phase_next = (action == ACT_READ) ? PH_RD_CMD : PH_WR_CMD;
            end
        end
        else
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                end
                PH_FILL:
                begin
                    if (count_reg < CNT_W'(INIT_FILL_BYTES))
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        sel_next   = 1'b0;
                        phase_next = PH_CMD0;
                        mosi       = frame_byte(PH_CMD0, 3'd0, addr_reg);
                        count_next = CNT_W'(1);
                    end
                end
                PH_CMD0, PH_CMD1, PH_RD_CMD, PH_WR_CMD:
                begin
                    if (count_reg < CNT_W'(6))
                    begin
                        mosi       = frame_byte(phase_reg, count_reg[2:0], addr_reg);
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        case (phase_reg)
                            PH_CMD0:   phase_next = PH_R1_0;
                            PH_CMD1:   phase_next = PH_R1_1;
                            PH_RD_CMD: phase_next = PH_RD_R1;
                            default:   phase_next = PH_WR_R1;
                        endcase
                    end
                end
                PH_R1_0:
                begin
                    if (!miso[7])
                    begin
                        phase_next = PH_CMD1;
                        mosi       = frame_byte(PH_CMD1, 3'd0, addr_reg);
                        count_next = CNT_W'(1);
                    end
                end
                PH_R1_1:
                begin
                    if (!miso[7])
                    begin
                        if (miso == 8'h00)
                        begin
                            fast_next  = 1'b1;
                            phase_next = PH_INIT_TAIL;
                        end
                        else
                        begin
                            mosi       = frame_byte(PH_CMD1, 3'd0, addr_reg);
                            count_next = CNT_W'(1);
                            phase_next = PH_CMD1;
                        end
                    end
                end
                PH_INIT_TAIL:
                begin
                    phase_next = PH_IDLE;
                    done       = 1'b1;
                end
                PH_RD_R1, PH_WR_R1:
                begin
                    if (!miso[7])
                    begin
                        if (miso[6:0] != 7'h00)
                        begin
                            status_next = ST_CMD_REJ;
                            sel_next    = 1'b1;
                            phase_next  = PH_IDLE;
                            done        = 1'b1;
                        end
                        else if (phase_reg == PH_RD_R1)
                        begin
                            phase_next = PH_RD_TOKEN;
                        end
                        else
                        begin
                            phase_next = PH_WR_PRE;
                            count_next = '0;
                        end
                    end
                end
                PH_RD_TOKEN:
                begin
                    if (miso == BLOCK_TOKEN)
                    begin
                        phase_next = PH_RD_DATA;
                        count_next = '0;
                    end
                end
                PH_RD_DATA:
                begin
                    rvalid = 1'b1;
                    rbyte  = miso;
                    if (count_reg == CNT_W'(SECTOR_BYTES - 1))
                    begin
                        phase_next = PH_RD_CRC;
                        count_next = '0;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                PH_RD_CRC:
                begin
                    if (count_reg == '0)
                    begin
                        count_next = CNT_W'(1);
                    end
                    else
                    begin
                        sel_next   = 1'b1;
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                end
                PH_WR_PRE:
                begin
                    if (count_reg == '0)
                    begin
                        count_next = CNT_W'(1);
                    end
                    else
                    begin
                        mosi       = BLOCK_TOKEN;
                        want       = 1'b1;
                        phase_next = PH_WR_DATA;
                        count_next = '0;
                    end
                end
                PH_WR_DATA:
                begin
                    mosi = wbyte;
                    if (count_reg == CNT_W'(SECTOR_BYTES - 1))
                    begin
                        phase_next = PH_WR_TAIL;
                        count_next = '0;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                        want       = 1'b1;
                    end
                end
                PH_WR_TAIL:
                begin
                    if (count_reg < CNT_W'(2))
                    begin
                        mosi       = FILLER;
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        phase_next = PH_WR_RESP;
                    end
                end
                PH_WR_RESP:
                begin
                    if (resp == RESP_OK)
                        status_next = ST_OK;
                    else if (resp == RESP_CRC)
                        status_next = ST_CRC_ERR;
                    else if (resp == RESP_WRERR)
                        status_next = ST_WR_ERR;
                    else
                        status_next = ST_RESP_ERR;
                    phase_next = PH_WR_BUSY;
                end
                PH_WR_BUSY:
                begin
                    if (miso != 8'h00)
                    begin
                        sel_next   = 1'b1;
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    assign busy = (phase_next != PH_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            count_reg  <= '0;
            addr_reg   <= '0;
            fast_reg   <= 1'b0;
            sel_reg    <= 1'b1;
            status_reg <= ST_OK;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            addr_reg   <= addr_next;
            fast_reg   <= fast_next;
            sel_reg    <= sel_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            out_valid_reg <= s_axis_tvalid;
        end
    end

    // result payload, loaded on every accepted transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= {status_next, done, busy, want, rbyte, fast_next, sel_next, mosi};
            out_user_reg <= rvalid;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

FILE: design/sdh_checker.sv
`include "sd_spi_host_sequencer_unit_macros.svh"

module sdh_checker
    import sdh_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  m_axis_tuser
);

    // a stalled result stays put
    `SDH_ASSERT_NEXT(a_stall_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // the finishing transfer leaves the sequencer idle
    `SDH_ASSERT_IMPL(a_done_idle, clk, rst_n, m_axis_tvalid && m_axis_tdata[OUT_DONE_BIT], !m_axis_tdata[OUT_BUSY_BIT])

    // sector data only shows up mid-operation with the card selected
    `SDH_ASSERT_IMPL(a_read_busy, clk, rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata[OUT_BUSY_BIT] && !m_axis_tdata[OUT_CSN_BIT])

    // a write byte request only during an operation with the card selected
    `SDH_ASSERT_IMPL(a_want_busy, clk, rst_n, m_axis_tvalid && m_axis_tdata[OUT_WANT_BIT], m_axis_tdata[OUT_BUSY_BIT] && !m_axis_tdata[OUT_CSN_BIT] && !m_axis_tuser)

endmodule

bind sd_spi_host_sequencer_unit sdh_checker u_sdh_checker (.*);
